>>> design/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants, instruction classes and beat types for the pipeline
// stall scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    // Sizing of the scheduler.
    localparam int HISTORY_DEPTH = 3;
    localparam int REG_COUNT     = 32;
    localparam int CYCLE_BITS    = 16;

    localparam int REG_BITS   = $clog2(REG_COUNT);
    localparam int CNT_BITS   = $clog2(HISTORY_DEPTH + 1);
    localparam int MODE_BITS  = 3;
    localparam int GAP_BITS   = 3;
    localparam int STALL_BITS = 3;
    localparam int TOTAL_BITS = CYCLE_BITS + 1;

    // Cycles from fetch until an instruction leaves writeback.
    localparam int BASE_LATENCY = 5;

    // Hazard gap after reset.
    localparam logic [GAP_BITS-1:0] GAP_RESET = GAP_BITS'(4);

    // Instruction classes.
    localparam logic [MODE_BITS-1:0] MODE_ALU    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_STORE  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_BRANCH = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_JUMP   = 3'd4;

    // One decoded instruction beat.
    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [REG_BITS-1:0]  target;
        logic [REG_BITS-1:0]  src1;
        logic [REG_BITS-1:0]  src2;
    } instr_t;

    // One remembered instruction.
    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [REG_BITS-1:0]   target;
        logic [CYCLE_BITS-1:0] issue;
    } hist_entry_t;

    // Whole history, newest entry at index 0, plus the fill count.
    typedef struct packed {
        hist_entry_t [HISTORY_DEPTH-1:0] entry;
        logic [CNT_BITS-1:0]             count;
    } hist_t;

    // One result beat.
    typedef struct packed {
        logic [CYCLE_BITS-1:0] issue;
        logic [STALL_BITS-1:0] stall;
        logic [TOTAL_BITS-1:0] total;
    } result_t;

endpackage

`default_nettype wire

>>> design/pipeline_stall_scheduler.sv
// ----------------------------------------------------------------------------
// pipeline_stall_scheduler
// Issue scheduler for a five-stage in-order pipeline without forwarding.
//
// Usage:
//   Decoded instructions arrive in execution order on the instr channel
//   (instr_valid / instr_stall). Each beat yields one beat on the result
//   channel (result_valid / result_stall) with the issue cycle, the bubbles
//   inserted before it and the cycle it leaves writeback.
//   The hazard gap is written through cfg_valid / cfg_ready / cfg_data; the user
//   must write it only while the block is idle, which the block itself does
//   not enforce; cfg_ready is always high. A beat passes through the input
//   register, then the result register. Throughput is one instruction per
//   cycle while the receiver does not stall, set by the single pass through the
//   history compare and the max select between those two registers; the
//   history updates as each instruction moves into the result register.
//   Reset empties both registers and the history and sets the gap to four.
//   When the receiver stalls, the result holds; the input register still
//   takes one more beat, and instr_stall rises only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pipeline_stall_scheduler
    import pss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [GAP_BITS-1:0]   cfg_data,

    input  wire logic                  instr_valid,
    output logic                       instr_stall,
    input  wire logic [MODE_BITS-1:0]  mode,
    input  wire logic [REG_BITS-1:0]   target_reg,
    input  wire logic [REG_BITS-1:0]   src1_reg,
    input  wire logic [REG_BITS-1:0]   src2_reg,

    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [CYCLE_BITS-1:0]      issue_cycle,
    output logic [STALL_BITS-1:0]      stall_cycles,
    output logic [TOTAL_BITS-1:0]      total_cycles
);

    logic [GAP_BITS-1:0] gap_reg;
    logic                in_vld_reg;
    logic                in_vld_next;
    instr_t              in_data_reg;
    logic                res_vld_reg;
    logic                res_vld_next;
    result_t             res_data_reg;
    logic                advance;
    logic                accept_in;
    logic                move;
    hist_t               hist;
    result_t             result;
    hist_entry_t         new_entry;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gap_reg <= cfg_data;
        end
    end

    // Handshake: the result register frees when empty or when its beat is taken.
    assign advance     = !res_vld_reg || !result_stall;
    assign move        = in_vld_reg && advance;
    assign instr_stall = in_vld_reg && !advance;
    assign accept_in   = instr_valid && !instr_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept_in)
        begin
            in_vld_next = 1'b1;
        end
        else if (move)
        begin
            in_vld_next = 1'b0;
        end
        res_vld_next = advance ? move : res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_data_reg.mode   <= mode;
            in_data_reg.target <= target_reg;
            in_data_reg.src1   <= src1_reg;
            in_data_reg.src2   <= src2_reg;
        end
        if (move)
        begin
            res_data_reg <= result;
        end
    end

    // Hazard resolution against the history.
    pss_resolve u_resolve (
        .instr     (in_data_reg),
        .hist      (hist),
        .gap       (gap_reg),
        .result    (result),
        .new_entry (new_entry)
    );

    pss_history u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (move),
        .push_entry (new_entry),
        .hist       (hist)
    );

    assign result_valid = res_vld_reg;
    assign issue_cycle  = res_data_reg.issue;
    assign stall_cycles = res_data_reg.stall;
    assign total_cycles = res_data_reg.total;

    // The input side stalls only when both registers are full and the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        instr_stall |-> in_vld_reg && res_vld_reg && result_stall)
    else $error("input stalled without a full pipeline");

    // An instruction that moves on always shows up as a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        move |=> result_valid)
    else $error("moved instruction lost");

    // The first instruction after reset issues in cycle zero with no bubbles.
    assert property (@(posedge clk) disable iff (!rst_n)
        move && (hist.count == '0) |=> (issue_cycle == '0) && (stall_cycles == '0))
    else $error("first instruction not issued in cycle zero");

    // Total cycles track the issue cycle by the base latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        move |=> total_cycles == {1'b0, issue_cycle} + TOTAL_BITS'(BASE_LATENCY))
    else $error("total cycles out of step with issue cycle");

endmodule

`default_nettype wire

>>> design/pss_history.sv
// ----------------------------------------------------------------------------
// pss_history
// Shift register of the most recent issued instructions with a saturating
// fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_history
    import pss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire hist_entry_t push_entry,
    output hist_t            hist
);

    hist_entry_t [HISTORY_DEPTH-1:0] entry_reg;
    logic [CNT_BITS-1:0]             count_reg;
    logic [CNT_BITS-1:0]             count_next;

    // Count saturates once the history is full.
    always_comb
    begin
        count_next = count_reg;
        if (push && (count_reg < CNT_BITS'(HISTORY_DEPTH)))
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entries shift toward older positions on every push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int k = HISTORY_DEPTH - 1; k > 0; k--)
            begin
                entry_reg[k] <= entry_reg[k-1];
            end
            entry_reg[0] <= push_entry;
        end
    end

    assign hist.entry = entry_reg;
    assign hist.count = count_reg;

    // The fill count never passes the history depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(HISTORY_DEPTH))
    else $error("history count above depth");

    // A push into a history that is not full grows the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && (count_reg < CNT_BITS'(HISTORY_DEPTH))
        |=> count_reg == $past(count_reg) + CNT_BITS'(1))
    else $error("history count did not advance on push");

endmodule

`default_nettype wire

>>> design/pss_resolve.sv
// ----------------------------------------------------------------------------
// pss_resolve
// Hazard check of one instruction against the history and computation of
// its issue cycle, bubble count and total cycle count.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_resolve
    import pss_pkg::*;
(
    input  wire instr_t              instr,
    input  wire hist_t               hist,
    input  wire logic [GAP_BITS-1:0] gap,
    output result_t                  result,
    output hist_entry_t              new_entry
);

    // Does a class read register r through its sources?
    function automatic logic reads_reg(
        input logic [MODE_BITS-1:0] m,
        input logic [REG_BITS-1:0]  s1,
        input logic [REG_BITS-1:0]  s2,
        input logic [REG_BITS-1:0]  r
    );
        logic hit;
        case (m)
            MODE_ALU, MODE_BRANCH: hit = (s1 == r) || (s2 == r);
            MODE_LOAD, MODE_STORE: hit = (s1 == r);
            default:               hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Data conflict between an older producer and the new instruction.
    function automatic logic conflicts(
        input hist_entry_t p,
        input instr_t      c
    );
        logic has_target;
        logic raw;
        logic load_store;
        has_target = (p.mode == MODE_ALU) || (p.mode == MODE_LOAD)
                     || (p.mode == MODE_STORE);
        raw        = has_target && reads_reg(c.mode, c.src1, c.src2, p.target);
        load_store = (p.mode == MODE_LOAD) && (c.mode == MODE_STORE)
                     && (p.target == c.target);
        return raw || load_store;
    endfunction

    logic                  hit;
    logic [TOTAL_BITS-1:0] need;
    logic [TOTAL_BITS-1:0] base;
    logic [TOTAL_BITS-1:0] pos;
    logic [TOTAL_BITS-1:0] diff;
    logic [CYCLE_BITS-1:0] issue;

    // The nearest conflicting producer sets the earliest issue.
    always_comb
    begin
        hit  = 1'b0;
        need = '0;
        base = {1'b0, hist.entry[0].issue} + TOTAL_BITS'(1);
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            if (!hit && (CNT_BITS'(k) < hist.count) && conflicts(hist.entry[k], instr))
            begin
                hit  = 1'b1;
                need = {1'b0, hist.entry[k].issue} + TOTAL_BITS'(gap);
            end
        end
        if (hist.count == '0)
        begin
            base = '0;
            pos  = '0;
        end
        else if (hit && (need > base))
        begin
            pos = need;
        end
        else
        begin
            pos = base;
        end
        diff = pos - base;
    end

    // Saturate the issue cycle at the top of its range.
    assign issue = pos[CYCLE_BITS] ? '1 : pos[CYCLE_BITS-1:0];

    assign result.issue = issue;
    assign result.stall = diff[STALL_BITS-1:0];
    assign result.total = {1'b0, issue} + TOTAL_BITS'(BASE_LATENCY);

    assign new_entry.mode   = instr.mode;
    assign new_entry.target = instr.target;
    assign new_entry.issue  = issue;

endmodule

`default_nettype wire

>>> test/pipeline_stall_scheduler_test.sv
// ----------------------------------------------------------------------------
// pipeline_stall_scheduler_test
// Self-checking bench for the pipeline stall scheduler. A short table of
// directed instructions covers each instruction class, the undefined classes,
// the register extremes and the hazard rules. Random instruction streams then
// run under every hazard gap setting. A final dependent chain runs at the
// widest gap. A local scheduler model predicts every result beat, and both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pipeline_stall_scheduler_test;
    import pss_pkg::*;

    // Classes that the decoder never names; they read and write nothing.
    localparam logic [MODE_BITS-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_RSVD7 = 3'd7;

    localparam int      ITEMS_PER_GAP = 200;
    localparam int      CHAIN_ITEMS   = 40;
    localparam result_t NO_RESULT     = '0;

    // One row of the directed table; fixed rows carry a typed-in result.
    typedef struct {
        instr_t  ins;
        bit      fixed;
        result_t want;
    } step_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [GAP_BITS-1:0]   cfg_data     = '0;
    logic                  instr_valid  = 1'b0;
    logic                  instr_stall;
    logic [MODE_BITS-1:0]  mode         = '0;
    logic [REG_BITS-1:0]   target_reg   = '0;
    logic [REG_BITS-1:0]   src1_reg     = '0;
    logic [REG_BITS-1:0]   src2_reg     = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [CYCLE_BITS-1:0] issue_cycle;
    logic [STALL_BITS-1:0] stall_cycles;
    logic [TOTAL_BITS-1:0] total_cycles;

    // Scheduler model state: newest instruction at index 0.
    logic [MODE_BITS-1:0]  hist_mode   [HISTORY_DEPTH];
    logic [REG_BITS-1:0]   hist_target [HISTORY_DEPTH];
    logic [CYCLE_BITS-1:0] hist_issue  [HISTORY_DEPTH];
    int                    hist_fill = 0;
    logic [GAP_BITS-1:0]   gap_now   = GAP_RESET;

    result_t     pending_results[$];
    result_t     want_beat;
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          instrs_sent    = 0;
    int          gaps_written   = 0;
    bit          steady         = 1'b0;
    int unsigned stall_run      = 0;
    int unsigned stall_pick;

    logic [GAP_BITS-1:0] phase_gaps [8] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};

    // Directed instructions, run under the reset gap of four.
    step_row_t directed_rows [24] = '{
        '{'{MODE_ALU,    5'd1,  5'd0,  5'd0},  1'b1, '{16'd0, 3'd0, 17'd5}},
        '{'{MODE_ALU,    5'd2,  5'd1,  5'd0},  1'b1, '{16'd4, 3'd3, 17'd9}},
        '{'{MODE_JUMP,   5'd31, 5'd31, 5'd31}, 1'b0, NO_RESULT},
        '{'{MODE_LOAD,   5'd3,  5'd31, 5'd2},  1'b0, NO_RESULT},
        '{'{MODE_STORE,  5'd3,  5'd5,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_BRANCH, 5'd0,  5'd0,  5'd3},  1'b0, NO_RESULT},
        '{'{MODE_RSVD5,  5'd3,  5'd3,  5'd3},  1'b0, NO_RESULT},
        '{'{MODE_RSVD6,  5'd31, 5'd31, 5'd31}, 1'b0, NO_RESULT},
        '{'{MODE_RSVD7,  5'd31, 5'd31, 5'd31}, 1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd31, 5'd31, 5'd31}, 1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd0,  5'd31, 5'd31}, 1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd5,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd6,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_BRANCH, 5'd0,  5'd5,  5'd6},  1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd7,  5'd1,  5'd1},  1'b0, NO_RESULT},
        '{'{MODE_JUMP,   5'd0,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_JUMP,   5'd0,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd8,  5'd7,  5'd7},  1'b0, NO_RESULT},
        '{'{MODE_JUMP,   5'd0,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_JUMP,   5'd0,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_JUMP,   5'd0,  5'd0,  5'd0},  1'b0, NO_RESULT},
        '{'{MODE_ALU,    5'd9,  5'd8,  5'd8},  1'b0, NO_RESULT},
        '{'{MODE_STORE,  5'd9,  5'd0,  5'd31}, 1'b0, NO_RESULT},
        '{'{MODE_LOAD,   5'd10, 5'd9,  5'd0},  1'b0, NO_RESULT}
    };

    pipeline_stall_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .mode         (mode),
        .target_reg   (target_reg),
        .src1_reg     (src1_reg),
        .src2_reg     (src2_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .issue_cycle  (issue_cycle),
        .stall_cycles (stall_cycles),
        .total_cycles (total_cycles)
    );

    // Clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Scheduler model: issue cycle of the next instruction, history update.
    function automatic result_t schedule_next(instr_t ins);
        logic [CYCLE_BITS:0]   base;
        logic [CYCLE_BITS:0]   pos;
        logic [CYCLE_BITS:0]   need;
        logic [CYCLE_BITS-1:0] issue;
        bit                    reads_target;
        bit                    found;
        int                    k;
        result_t               r;
        base  = '0;
        pos   = '0;
        found = 1'b0;
        if (hist_fill != 0)
        begin
            base = {1'b0, hist_issue[0]} + 1'b1;
            pos  = base;
            // Only the nearest conflicting producer counts.
            for (k = 0; k < HISTORY_DEPTH; k++)
            begin
                if (!found && k < hist_fill)
                begin
                    case (ins.mode)
                        MODE_ALU, MODE_BRANCH:
                            reads_target = ins.src1 == hist_target[k] ||
                                           ins.src2 == hist_target[k];
                        MODE_LOAD, MODE_STORE:
                            reads_target = ins.src1 == hist_target[k];
                        default:
                            reads_target = 1'b0;
                    endcase
                    if ((hist_mode[k] <= MODE_STORE && reads_target) ||
                        (hist_mode[k] == MODE_LOAD && ins.mode == MODE_STORE &&
                         hist_target[k] == ins.target))
                    begin
                        found = 1'b1;
                        need  = {1'b0, hist_issue[k]} + gap_now;
                        if (need > pos)
                            pos = need;
                    end
                end
            end
        end
        // Bit CYCLE_BITS set means the issue cycle ran past its maximum.
        issue   = pos[CYCLE_BITS] ? '1 : pos[CYCLE_BITS-1:0];
        r.issue = issue;
        r.stall = STALL_BITS'(pos - base);
        r.total = TOTAL_BITS'(issue) + TOTAL_BITS'(BASE_LATENCY);
        for (k = HISTORY_DEPTH - 1; k > 0; k--)
        begin
            hist_mode[k]   = hist_mode[k-1];
            hist_target[k] = hist_target[k-1];
            hist_issue[k]  = hist_issue[k-1];
        end
        hist_mode[0]   = ins.mode;
        hist_target[0] = ins.target;
        hist_issue[0]  = issue;
        if (hist_fill < HISTORY_DEPTH)
            hist_fill++;
        return r;
    endfunction

    // Registers mostly from a small pool so that hazards come often.
    function automatic logic [REG_BITS-1:0] pick_reg();
        if ($urandom_range(0, 99) < 70)
            return REG_BITS'($urandom_range(0, 3));
        return REG_BITS'($urandom_range(0, REG_COUNT - 1));
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        if ($urandom_range(0, 99) < 88)
            ins.mode = MODE_BITS'($urandom_range(MODE_ALU, MODE_JUMP));
        else
            ins.mode = MODE_BITS'($urandom_range(MODE_RSVD5, MODE_RSVD7));
        ins.target = pick_reg();
        ins.src1   = pick_reg();
        ins.src2   = pick_reg();
        return ins;
    endfunction

    // Send one instruction beat after a random gap and queue its result.
    task automatic send_instr(input instr_t ins, input bit fixed, input result_t want);
        int          gap_len;
        int unsigned gap_pick;
        result_t     predicted;
        gap_len  = 0;
        gap_pick = $urandom_range(0, 99);
        if (!steady)
        begin
            if (gap_pick >= 95)
                gap_len = $urandom_range(10, 30);
            else if (gap_pick >= 80)
                gap_len = $urandom_range(1, 4);
            else if (gap_pick >= 60)
                gap_len = 1;
        end
        if (gap_len > 0)
        begin
            instr_valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
        instr_valid <= 1'b1;
        mode        <= ins.mode;
        target_reg  <= ins.target;
        src1_reg    <= ins.src1;
        src2_reg    <= ins.src2;
        do
            @(posedge clk);
        while (instr_stall);
        predicted = schedule_next(ins);
        pending_results.push_back(fixed ? want : predicted);
        instrs_sent++;
    endtask

    // Write the hazard gap once every outstanding result has come back.
    task automatic write_gap(input logic [GAP_BITS-1:0] value);
        instr_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gap_now = value;
        gaps_written++;
    endtask

    // Receiver stalls in runs: mostly short, a few long, some long clear stretches.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55)
            begin
                result_stall <= 1'b0;
                stall_run = $urandom_range(1, 6);
            end
            else if (stall_pick < 85)
            begin
                result_stall <= 1'b1;
                stall_run = $urandom_range(1, 3);
            end
            else if (stall_pick < 93)
            begin
                result_stall <= 1'b1;
                stall_run = $urandom_range(8, 24);
            end
            else
            begin
                result_stall <= 1'b0;
                stall_run = $urandom_range(40, 120);
            end
        end
        else
            stall_run--;
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, issue_cycle %0d",
                         $time, issue_cycle);
                mismatch_count++;
            end
            else
            begin
                want_beat = pending_results.pop_front();
                if (issue_cycle !== want_beat.issue)
                begin
                    $display("%0t: issue_cycle expected %0d, actual %0d",
                             $time, want_beat.issue, issue_cycle);
                    mismatch_count++;
                end
                if (stall_cycles !== want_beat.stall)
                begin
                    $display("%0t: stall_cycles expected %0d, actual %0d",
                             $time, want_beat.stall, stall_cycles);
                    mismatch_count++;
                end
                if (total_cycles !== want_beat.total)
                begin
                    $display("%0t: total_cycles expected %0d, actual %0d",
                             $time, want_beat.total, total_cycles);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, dependent chain.
    initial
    begin
        instr_t              ins;
        logic [REG_BITS-1:0] chain_reg;
        int                  n;
        for (n = 0; n < HISTORY_DEPTH; n++)
        begin
            hist_mode[n]   = '0;
            hist_target[n] = '0;
            hist_issue[n]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_instr(directed_rows[i].ins, directed_rows[i].fixed, directed_rows[i].want);

        // Random streams under each gap setting, with some stretches held steady.
        foreach (phase_gaps[p])
        begin
            write_gap(phase_gaps[p]);
            for (n = 0; n < ITEMS_PER_GAP; n++)
            begin
                if (n % 50 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_instr(random_instr(), 1'b0, NO_RESULT);
            end
        end
        steady = 1'b0;

        // Dependent chain at the widest gap; every beat after the first waits on its producer.
        write_gap(3'd7);
        chain_reg = pick_reg();
        for (n = 0; n < CHAIN_ITEMS; n++)
        begin
            ins.mode   = MODE_ALU;
            ins.target = REG_BITS'($urandom_range(0, REG_COUNT - 1));
            ins.src1   = chain_reg;
            ins.src2   = REG_BITS'($urandom_range(0, REG_COUNT - 1));
            chain_reg  = ins.target;
            send_instr(ins, 1'b0, NO_RESULT);
        end

        instr_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d instructions, compared %0d result beats, %0d gap writes.",
                 instrs_sent, results_seen, gaps_written);
        $display("Hazard gaps 0 to 7 covered, closing with a dependent chain at gap 7.");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #40000000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
